[rtl/core/uer_pkg.sv]
`timescale 1ns / 1ps

package uer_pkg;

    // Field and register widths
    localparam int COUNT_W = 22;     // measurement timer
    localparam int CLK_W   = 28;     // clock_hz register
    localparam int TRIG_W  = 12;     // trigger_ticks register
    localparam int TMO_W   = 22;     // timeout_ticks register
    localparam int DIST_W  = 12;     // distance_mm result
    localparam int IDX_W   = 2;      // config register index
    localparam int CMP_W   = (COUNT_W > TMO_W) ? COUNT_W : TMO_W;

    // Conversion: mm = floor(width * SPEED_NUM / clock_hz) - OFFSET_MM
    localparam int unsigned SPEED_NUM = 190000;
    localparam int SPEED_W   = 18;
    localparam int PROD_W    = COUNT_W + SPEED_W;
    localparam int DIV_CNT_W = $clog2(PROD_W + 1);
    localparam int unsigned OFFSET_MM = 14;
    localparam int unsigned MAX_MM    = 4000;

    // Reset values of the config registers
    localparam logic [CLK_W-1:0]  CLOCK_HZ_RST = CLK_W'(80000000);
    localparam logic [TRIG_W-1:0] TRIG_RST     = TRIG_W'(1200);
    localparam logic [TMO_W-1:0]  TMO_RST      = TMO_W'(1200000);

    // Config register indexes
    localparam logic [IDX_W-1:0] REG_CLOCK_HZ = 2'd0;
    localparam logic [IDX_W-1:0] REG_TRIG     = 2'd1;
    localparam logic [IDX_W-1:0] REG_TIMEOUT  = 2'd2;

    // Measurement phase
    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_TRIG  = 2'd1,
        PH_WAIT1 = 2'd2,
        PH_WAIT2 = 2'd3
    } t_phase;

    // Item sequencer
    typedef enum logic [1:0] {
        SEQ_RUN = 2'd0,
        SEQ_MUL = 2'd1,
        SEQ_DIV = 2'd2,
        SEQ_FIN = 2'd3
    } t_seq;

    // Source of the distance field
    typedef enum logic [1:0] {
        DIST_ZERO = 2'd0,
        DIST_MAX  = 2'd1,
        DIST_QUO  = 2'd2
    } t_dist_sel;

    typedef struct packed {
        logic      echo_load;
        logic      trig_clear;
        logic      trig_inc;
        logic      timer_clear;
        logic      timer_inc;
        logic      capture;
        logic      width_load;
        logic      mul_start;
        logic      div_step;
        logic      out_load;
        logic      out_trig;
        logic      out_busy;
        logic      out_done;
        logic      out_tmo;
        t_dist_sel dist_sel;
    } t_cmd;

    typedef struct packed {
        logic echo_edge;
        logic trig_end;
        logic timeout;
        logic div_last;
        logic out_free;
    } t_sts;

endpackage

[rtl/core/ultrasonic_echo_ranger.sv]
`timescale 1ns / 1ps

// Ultrasonic echo ranger. Each input item is one tick of the sampling clock
// carrying the echo pin level, or a start command; every item returns exactly
// one result item with the trigger pin level, busy, done, distance in mm and a
// timeout flag. A start in idle drives the trigger for trigger_ticks items
// (one if zero), then a timer runs: the first echo change captures it, the
// second ends the measurement with distance = floor(width * 190000 /
// clock_hz) - 14, clamped to 0..4000. Reaching timeout_ticks (or timer
// saturation) answers 4000 with the timeout flag. Timing: an ordinary item's
// result is loaded into the output register at the accepting edge, so items
// flow at one per cycle while the output side keeps up. The item carrying the
// closing echo edge captures the width at its accepting edge, then passes a
// multiply step, a 40-step restoring divider (one quotient bit per cycle) and
// a finish step that loads the result once the output register is free;
// no new item is taken meanwhile.
// Config writes are taken at any edge with i_cfg_we high, but must only be made
// while idle.

module ultrasonic_echo_ranger (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // config write port
    input  logic                       i_cfg_we,
    input  logic [uer_pkg::IDX_W-1:0]  i_cfg_index,
    input  logic [uer_pkg::CLK_W-1:0]  i_cfg_data,
    // input items
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic                       i_opcode,
    input  logic                       i_echo_level,
    // result items
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic                       o_trigger_level,
    output logic                       o_busy_res,
    output logic                       o_done_res,
    output logic [uer_pkg::DIST_W-1:0] o_distance_mm,
    output logic                       o_timed_out
);

    uer_pkg::t_cmd cmd;
    uer_pkg::t_sts sts;

    // phase and item sequencing
    uer_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_opcode   (i_opcode),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // counters, config, distance conversion and output register
    uer_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_echo_level    (i_echo_level),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_out_ready     (i_out_ready),
        .o_out_valid     (o_out_valid),
        .o_trigger_level (o_trigger_level),
        .o_busy_res      (o_busy_res),
        .o_done_res      (o_done_res),
        .o_distance_mm   (o_distance_mm),
        .o_timed_out     (o_timed_out)
    );

endmodule

[rtl/core/uer_ctrl.sv]
`timescale 1ns / 1ps

module uer_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  logic          i_opcode,
    input  uer_pkg::t_sts i_sts,
    output uer_pkg::t_cmd o_cmd
);

    uer_pkg::t_seq   r_seq,   n_seq;
    uer_pkg::t_phase r_phase, n_phase;
    logic            accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq   <= uer_pkg::SEQ_RUN;
            r_phase <= uer_pkg::PH_IDLE;
        end else begin
            r_seq   <= n_seq;
            r_phase <= n_phase;
        end
    end

    always_comb begin
        n_seq      = r_seq;
        n_phase    = r_phase;
        o_cmd      = '0;
        o_cmd.dist_sel = uer_pkg::DIST_ZERO;
        o_in_ready = (r_seq == uer_pkg::SEQ_RUN) && i_sts.out_free;
        accept     = o_in_ready && i_in_valid;

        unique case (r_seq)
            uer_pkg::SEQ_RUN: begin
                if (accept) begin
                    o_cmd.echo_load = 1'b1;
                    o_cmd.out_load  = 1'b1;
                    unique case (r_phase)
                        uer_pkg::PH_IDLE: begin
                            if (i_opcode) begin
                                n_phase          = uer_pkg::PH_TRIG;
                                o_cmd.trig_clear = 1'b1;
                                o_cmd.out_trig   = 1'b1;
                            end
                        end
                        uer_pkg::PH_TRIG: begin
                            o_cmd.trig_inc = 1'b1;
                            if (i_sts.trig_end) begin
                                n_phase           = uer_pkg::PH_WAIT1;
                                o_cmd.timer_clear = 1'b1;
                            end else begin
                                o_cmd.out_trig = 1'b1;
                            end
                        end
                        uer_pkg::PH_WAIT1, uer_pkg::PH_WAIT2: begin
                            o_cmd.timer_inc = 1'b1;
                            if (i_sts.echo_edge && r_phase == uer_pkg::PH_WAIT2) begin
                                // closing edge: result comes from the divider
                                n_phase          = uer_pkg::PH_IDLE;
                                n_seq            = uer_pkg::SEQ_MUL;
                                o_cmd.width_load = 1'b1;
                                o_cmd.out_load   = 1'b0;
                            end else begin
                                if (i_sts.echo_edge) begin
                                    o_cmd.capture = 1'b1;
                                    n_phase       = uer_pkg::PH_WAIT2;
                                end
                                if (i_sts.timeout) begin
                                    n_phase        = uer_pkg::PH_IDLE;
                                    o_cmd.out_done = 1'b1;
                                    o_cmd.out_tmo  = 1'b1;
                                    o_cmd.dist_sel = uer_pkg::DIST_MAX;
                                end
                            end
                        end
                        default: n_phase = uer_pkg::PH_IDLE;
                    endcase
                    o_cmd.out_busy = (n_phase != uer_pkg::PH_IDLE);
                end
            end
            uer_pkg::SEQ_MUL: begin
                o_cmd.mul_start = 1'b1;
                n_seq           = uer_pkg::SEQ_DIV;
            end
            uer_pkg::SEQ_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_seq = uer_pkg::SEQ_FIN;
                end
            end
            uer_pkg::SEQ_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_done = 1'b1;
                    o_cmd.dist_sel = uer_pkg::DIST_QUO;
                    n_seq          = uer_pkg::SEQ_RUN;
                end
            end
            default: n_seq = uer_pkg::SEQ_RUN;
        endcase
    end

endmodule

[rtl/core/uer_dpath.sv]
`timescale 1ns / 1ps

module uer_dpath (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [uer_pkg::IDX_W-1:0]        i_cfg_index,
    input  logic [uer_pkg::CLK_W-1:0]        i_cfg_data,
    input  logic                             i_echo_level,
    input  uer_pkg::t_cmd                    i_cmd,
    output uer_pkg::t_sts                    o_sts,
    input  logic                             i_out_ready,
    output logic                             o_out_valid,
    output logic                             o_trigger_level,
    output logic                             o_busy_res,
    output logic                             o_done_res,
    output logic [uer_pkg::DIST_W-1:0]       o_distance_mm,
    output logic                             o_timed_out
);

    localparam logic [uer_pkg::COUNT_W-1:0] TIMER_MAX = {uer_pkg::COUNT_W{1'b1}};

    logic [uer_pkg::CLK_W-1:0]     r_clock_hz;
    logic [uer_pkg::TRIG_W-1:0]    r_trig_ticks;
    logic [uer_pkg::TMO_W-1:0]     r_tmo_ticks;

    logic                          r_prev_echo;
    logic [uer_pkg::TRIG_W-1:0]    r_trig_cnt;
    logic [uer_pkg::COUNT_W-1:0]   r_timer;
    logic [uer_pkg::COUNT_W-1:0]   r_capture;
    logic [uer_pkg::COUNT_W-1:0]   r_width;

    // divider: r_quo shifts the dividend out at the top, quotient bits in at the bottom
    logic [uer_pkg::PROD_W-1:0]    r_quo;
    logic [uer_pkg::CLK_W-1:0]     r_rem;
    logic [uer_pkg::DIV_CNT_W-1:0] r_div_cnt;

    logic                          r_out_valid;
    logic                          r_trig;
    logic                          r_busy;
    logic                          r_done;
    logic [uer_pkg::DIST_W-1:0]    r_dist;
    logic                          r_tmo;

    logic [uer_pkg::COUNT_W-1:0]   timer_next;
    logic [uer_pkg::TRIG_W-1:0]    trig_cnt_next;
    logic [uer_pkg::CLK_W:0]       rem_sh;
    logic [uer_pkg::CLK_W:0]       rem_sub;
    logic                          rem_ge;
    logic [uer_pkg::DIST_W-1:0]    quo_dist;
    logic [uer_pkg::DIST_W-1:0]    n_dist;
    logic                          out_free;

    assign timer_next    = (r_timer == TIMER_MAX) ? r_timer : r_timer + 1'b1;
    assign trig_cnt_next = r_trig_cnt + 1'b1;
    assign rem_sh        = {r_rem, r_quo[uer_pkg::PROD_W-1]};
    assign rem_sub       = rem_sh - {1'b0, r_clock_hz};
    // clock_hz of zero: every step subtracts, quotient is all ones, saturates to max
    assign rem_ge        = (rem_sh >= {1'b0, r_clock_hz});
    assign out_free      = !r_out_valid || i_out_ready;

    always_comb begin
        if (r_quo < uer_pkg::PROD_W'(uer_pkg::OFFSET_MM)) begin
            quo_dist = '0;
        end else if (r_quo > uer_pkg::PROD_W'(uer_pkg::OFFSET_MM + uer_pkg::MAX_MM)) begin
            quo_dist = uer_pkg::DIST_W'(uer_pkg::MAX_MM);
        end else begin
            quo_dist = uer_pkg::DIST_W'(r_quo - uer_pkg::PROD_W'(uer_pkg::OFFSET_MM));
        end
    end

    always_comb begin
        case (i_cmd.dist_sel)
            uer_pkg::DIST_MAX: n_dist = uer_pkg::DIST_W'(uer_pkg::MAX_MM);
            uer_pkg::DIST_QUO: n_dist = quo_dist;
            default:           n_dist = '0;
        endcase
    end

    always_comb begin
        o_sts.echo_edge = (i_echo_level != r_prev_echo);
        o_sts.trig_end  = (trig_cnt_next >= r_trig_ticks);
        o_sts.timeout   = (uer_pkg::CMP_W'(timer_next) >= uer_pkg::CMP_W'(r_tmo_ticks))
                          || (timer_next == TIMER_MAX);
        o_sts.div_last  = (r_div_cnt == uer_pkg::DIV_CNT_W'(1));
        o_sts.out_free  = out_free;
    end

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock_hz   <= uer_pkg::CLOCK_HZ_RST;
            r_trig_ticks <= uer_pkg::TRIG_RST;
            r_tmo_ticks  <= uer_pkg::TMO_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                uer_pkg::REG_CLOCK_HZ: r_clock_hz   <= i_cfg_data;
                uer_pkg::REG_TRIG:     r_trig_ticks <= i_cfg_data[uer_pkg::TRIG_W-1:0];
                uer_pkg::REG_TIMEOUT:  r_tmo_ticks  <= i_cfg_data[uer_pkg::TMO_W-1:0];
                default: ;
            endcase
        end
    end

    // measurement counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_echo <= 1'b0;
            r_trig_cnt  <= '0;
            r_timer     <= '0;
            r_capture   <= '0;
        end else begin
            if (i_cmd.echo_load) begin
                r_prev_echo <= i_echo_level;
            end
            if (i_cmd.trig_clear) begin
                r_trig_cnt <= '0;
            end else if (i_cmd.trig_inc) begin
                r_trig_cnt <= trig_cnt_next;
            end
            if (i_cmd.timer_clear) begin
                r_timer   <= '0;
                r_capture <= '0;
            end else if (i_cmd.timer_inc) begin
                r_timer <= timer_next;
                if (i_cmd.capture) begin
                    r_capture <= timer_next;
                end
            end
        end
    end

    // width, product and divider
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_cnt <= '0;
        end else begin
            if (i_cmd.mul_start) begin
                r_div_cnt <= uer_pkg::DIV_CNT_W'(uer_pkg::PROD_W);
            end else if (i_cmd.div_step) begin
                r_div_cnt <= r_div_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.width_load) begin
            r_width <= timer_next - r_capture;
        end
        if (i_cmd.mul_start) begin
            r_quo <= uer_pkg::PROD_W'(r_width) * uer_pkg::PROD_W'(uer_pkg::SPEED_NUM);
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_quo <= {r_quo[uer_pkg::PROD_W-2:0], rem_ge};
            r_rem <= rem_ge ? rem_sub[uer_pkg::CLK_W-1:0] : rem_sh[uer_pkg::CLK_W-1:0];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_trig <= i_cmd.out_trig;
            r_busy <= i_cmd.out_busy;
            r_done <= i_cmd.out_done;
            r_tmo  <= i_cmd.out_tmo;
            r_dist <= n_dist;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_trigger_level = r_trig;
    assign o_busy_res      = r_busy;
    assign o_done_res      = r_done;
    assign o_distance_mm   = r_dist;
    assign o_timed_out     = r_tmo;

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import uer_pkg::*;

    // Item opcodes
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_START = 1'b1;

    localparam logic [COUNT_W-1:0] TIMER_TOP = '1;

    // One result item, fields in port order
    typedef struct packed {
        logic              trig;
        logic              busy;
        logic              done;
        logic [DIST_W-1:0] mm;
        logic              tmo;
    } res_t;

    // Directed table: register writes, items checked by the predictor, and
    // items whose result is typed in by hand
    typedef enum logic [1:0] {
        ROW_CFG  = 2'd0,
        ROW_ITEM = 2'd1,
        ROW_CHK  = 2'd2
    } row_kind_t;

    typedef struct packed {
        row_kind_t         kind;
        logic [IDX_W-1:0]  idx;
        logic [CLK_W-1:0]  data;
        logic              op;
        logic              echo;
        res_t              exp;
    } dir_row_t;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [IDX_W-1:0]    i_cfg_index;
    logic [CLK_W-1:0]    i_cfg_data;
    logic                i_in_valid;
    logic                o_in_ready;
    logic                i_opcode;
    logic                i_echo_level;
    logic                o_out_valid;
    logic                i_out_ready;
    logic                o_trigger_level;
    logic                o_busy_res;
    logic                o_done_res;
    logic [DIST_W-1:0]   o_distance_mm;
    logic                o_timed_out;

    ultrasonic_echo_ranger u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_opcode        (i_opcode),
        .i_echo_level    (i_echo_level),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_trigger_level (o_trigger_level),
        .o_busy_res      (o_busy_res),
        .o_done_res      (o_done_res),
        .o_distance_mm   (o_distance_mm),
        .o_timed_out     (o_timed_out)
    );

    // Ranger copy: register file and measurement state
    logic [CLK_W-1:0]   m_clk_hz;
    logic [TRIG_W-1:0]  m_trig_len;
    logic [TMO_W-1:0]   m_tmo_len;
    t_phase             m_phase;
    logic [TRIG_W-1:0]  m_trig_cnt;
    logic [COUNT_W-1:0] m_timer;
    logic [COUNT_W-1:0] m_capture;
    logic               m_prev_echo;
    int                 m_done_cnt;

    res_t     due_readings [$];   // readings owed by the block, oldest first
    dir_row_t dir_rows [$];
    int       field_errors;
    int       send_idle_pct;
    int       recv_idle_pct;
    int       echo_hold;          // ticks left before the next echo toggle
    bit       park_output;        // asks the output side for a long hold-off

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Pulse width in ticks -> mm, floor division then offset and clamp
    function automatic logic [DIST_W-1:0] mm_from_ticks(input logic [COUNT_W-1:0] w);
        logic [63:0] q;
        if (m_clk_hz == '0)
            return DIST_W'(MAX_MM);
        q = (64'(w) * 64'(SPEED_NUM)) / 64'(m_clk_hz);
        if (q < 64'(OFFSET_MM))
            return '0;
        q = q - 64'(OFFSET_MM);
        if (q > 64'(MAX_MM))
            return DIST_W'(MAX_MM);
        return q[DIST_W-1:0];
    endfunction

    // Advance the ranger copy by one item and return its reading
    function automatic res_t ranger_next(input logic op, input logic echo);
        res_t r;
        logic toggled;
        r = '0;
        toggled = (echo != m_prev_echo);
        case (m_phase)
            PH_IDLE: begin
                if (op == OP_START) begin
                    m_phase    = PH_TRIG;
                    m_trig_cnt = '0;
                    r.trig     = 1'b1;
                end
            end
            PH_TRIG: begin
                // echo changes are ignored while the trigger is high
                m_trig_cnt = m_trig_cnt + 1'b1;
                if (m_trig_cnt >= m_trig_len) begin
                    m_phase   = PH_WAIT1;
                    m_timer   = '0;
                    m_capture = '0;
                end else begin
                    r.trig = 1'b1;
                end
            end
            default: begin
                if (m_timer != TIMER_TOP)
                    m_timer = m_timer + 1'b1;
                if (toggled && m_phase == PH_WAIT1) begin
                    m_capture = m_timer;
                    m_phase   = PH_WAIT2;
                end else if (toggled) begin
                    r.mm    = mm_from_ticks(m_timer - m_capture);
                    r.done  = 1'b1;
                    m_phase = PH_IDLE;
                end
                // a closing edge on the timeout tick wins over the timeout
                if (!r.done && (m_timer >= m_tmo_len || m_timer == TIMER_TOP)) begin
                    r.mm    = DIST_W'(MAX_MM);
                    r.done  = 1'b1;
                    r.tmo   = 1'b1;
                    m_phase = PH_IDLE;
                end
            end
        endcase
        if (r.done)
            m_done_cnt++;
        m_prev_echo = echo;
        r.busy = (m_phase != PH_IDLE);
        return r;
    endfunction

    function automatic int pick_hold();
        case ($urandom_range(9))
            0:       return $urandom_range(100, 600);  // long: hits small timeouts
            1, 2:    return $urandom_range(0, 3);
            default: return $urandom_range(0, 40);
        endcase
    endfunction

    // Mostly well-formed measurements steered by the copy's phase, some noise
    task automatic pick_item(output logic op, output logic echo);
        if ($urandom_range(9) == 0) begin
            op   = 1'($urandom_range(1));
            echo = 1'($urandom_range(1));
        end else begin
            case (m_phase)
                PH_IDLE: begin
                    op        = ($urandom_range(7) != 0);
                    echo      = m_prev_echo ^ ($urandom_range(3) == 0);
                    echo_hold = pick_hold();
                end
                PH_TRIG: begin
                    op        = ($urandom_range(15) == 0);
                    echo      = 1'($urandom_range(1));
                    echo_hold = pick_hold();
                end
                default: begin
                    op = ($urandom_range(31) == 0);
                    if (echo_hold == 0) begin
                        echo      = ~m_prev_echo;
                        echo_hold = pick_hold();
                    end else begin
                        echo      = m_prev_echo;
                        echo_hold = echo_hold - 1;
                    end
                end
            endcase
        end
    endtask

    // Offer one item (after a random gap) and wait for the handshake
    task automatic offer_item(input logic op, input logic echo, output res_t want);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_opcode     <= op;
        i_echo_level <= echo;
        do @(posedge i_clk); while (!o_in_ready);
        want = ranger_next(op, echo);
    endtask

    // Stop offering and let every owed reading come back
    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (due_readings.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CLK_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_CLOCK_HZ: m_clk_hz   = val;
            REG_TRIG:     m_trig_len = val[TRIG_W-1:0];
            REG_TIMEOUT:  m_tmo_len  = val[TMO_W-1:0];
            default: ;
        endcase
    endtask

    // One random phase: idle, set all registers, then n items (more if the
    // phase must see min_done completed measurements)
    task automatic run_phase(input logic [CLK_W-1:0] hz, input logic [TRIG_W-1:0] trig,
                             input logic [TMO_W-1:0] tmo, input int n, input int min_done,
                             input int s_pct, input int r_pct, input bit park);
        int   sent;
        int   done_base;
        logic op;
        logic echo;
        res_t want;
        settle();
        write_reg(REG_CLOCK_HZ, hz);
        write_reg(REG_TRIG, CLK_W'(trig));
        write_reg(REG_TIMEOUT, CLK_W'(tmo));
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        if (park)
            park_output = 1'b1;
        done_base = m_done_cnt;
        sent = 0;
        while (sent < n || m_done_cnt - done_base < min_done) begin
            pick_item(op, echo);
            offer_item(op, echo, want);
            due_readings.push_back(want);
            sent++;
        end
    endtask

    function automatic dir_row_t cfg_row(input logic [IDX_W-1:0] idx,
                                         input logic [CLK_W-1:0] val);
        dir_row_t r;
        r      = '0;
        r.kind = ROW_CFG;
        r.idx  = idx;
        r.data = val;
        return r;
    endfunction

    function automatic dir_row_t item_row(input logic op, input logic echo);
        dir_row_t r;
        r      = '0;
        r.kind = ROW_ITEM;
        r.op   = op;
        r.echo = echo;
        return r;
    endfunction

    function automatic dir_row_t chk_row(input logic op, input logic echo, input logic trig,
                                         input logic busy, input logic done,
                                         input logic [DIST_W-1:0] mm, input logic tmo);
        dir_row_t r;
        r      = '0;
        r.kind = ROW_CHK;
        r.op   = op;
        r.echo = echo;
        r.exp  = '{trig: trig, busy: busy, done: done, mm: mm, tmo: tmo};
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [DIST_W-1:0] want,
                                 input logic [DIST_W-1:0] got);
        if (got !== want) begin
            $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
            field_errors++;
        end
    endtask

    // Output side: random ready, plus one long hold-off on request so the
    // block backs up and drops o_in_ready while items keep coming
    initial begin : out_side
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (park_output) begin
                i_out_ready <= 1'b0;
                repeat (250) @(negedge i_clk);
                park_output = 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Reading check: every accepted result against the oldest owed reading
    always @(posedge i_clk) begin : result_check
        res_t got;
        res_t want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = {o_trigger_level, o_busy_res, o_done_res, o_distance_mm, o_timed_out};
            if (due_readings.size() == 0) begin
                $display("%0t ns: result with no item owed, got %p", $time, got);
                field_errors++;
            end else begin
                want = due_readings.pop_front();
                compare_field("trigger_level", DIST_W'(want.trig), DIST_W'(got.trig));
                compare_field("busy_res", DIST_W'(want.busy), DIST_W'(got.busy));
                compare_field("done_res", DIST_W'(want.done), DIST_W'(got.done));
                compare_field("distance_mm", want.mm, got.mm);
                compare_field("timed_out", DIST_W'(want.tmo), DIST_W'(got.tmo));
            end
        end
    end

    initial begin : stimulus
        res_t want;

        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_index  = '0;
        i_cfg_data   = '0;
        i_in_valid   = 1'b0;
        i_opcode     = OP_TICK;
        i_echo_level = 1'b0;

        // register file and state after reset
        m_clk_hz     = CLOCK_HZ_RST;
        m_trig_len   = TRIG_RST;
        m_tmo_len    = TMO_RST;
        m_phase      = PH_IDLE;
        m_trig_cnt   = '0;
        m_timer      = '0;
        m_capture    = '0;
        m_prev_echo  = 1'b0;
        m_done_cnt   = 0;
        field_errors = 0;
        echo_hold    = 0;
        park_output  = 1'b0;

        send_idle_pct = 6;
        recv_idle_pct = 78;

        dir_rows = '{
            // ticks while idle, straight out of reset
            chk_row(OP_TICK,  1'b0, 1'b0, 1'b0, 1'b0, 12'd0, 1'b0),
            chk_row(OP_TICK,  1'b1, 1'b0, 1'b0, 1'b0, 12'd0, 1'b0),
            // zero pulse length, zero timeout, zero clock
            cfg_row(REG_TRIG, 28'd0),
            cfg_row(REG_TIMEOUT, 28'd0),
            cfg_row(REG_CLOCK_HZ, 28'd0),
            chk_row(OP_START, 1'b1, 1'b1, 1'b1, 1'b0, 12'd0, 1'b0),
            chk_row(OP_TICK,  1'b0, 1'b0, 1'b1, 1'b0, 12'd0, 1'b0),
            chk_row(OP_TICK,  1'b0, 1'b0, 1'b0, 1'b1, 12'd4000, 1'b1),
            chk_row(OP_START, 1'b0, 1'b1, 1'b1, 1'b0, 12'd0, 1'b0),
            chk_row(OP_TICK,  1'b0, 1'b0, 1'b1, 1'b0, 12'd0, 1'b0),
            item_row(OP_TICK, 1'b1),    // first edge on a timeout tick
            // closing edge lands on the timeout tick, zero clock gives max
            cfg_row(REG_TIMEOUT, 28'd3),
            chk_row(OP_START, 1'b1, 1'b1, 1'b1, 1'b0, 12'd0, 1'b0),
            chk_row(OP_TICK,  1'b1, 1'b0, 1'b1, 1'b0, 12'd0, 1'b0),
            chk_row(OP_TICK,  1'b0, 1'b0, 1'b1, 1'b0, 12'd0, 1'b0),
            item_row(OP_TICK, 1'b0),
            chk_row(OP_TICK,  1'b1, 1'b0, 1'b0, 1'b1, 12'd4000, 1'b0),
            // start while busy, echo toggles under the trigger, shortest pulse
            cfg_row(REG_CLOCK_HZ, 28'd19000),
            cfg_row(REG_TRIG, 28'd3),
            cfg_row(REG_TIMEOUT, 28'h3FFFFF),
            chk_row(OP_START, 1'b1, 1'b1, 1'b1, 1'b0, 12'd0, 1'b0),
            chk_row(OP_TICK,  1'b0, 1'b1, 1'b1, 1'b0, 12'd0, 1'b0),
            chk_row(OP_START, 1'b1, 1'b1, 1'b1, 1'b0, 12'd0, 1'b0),
            chk_row(OP_TICK,  1'b1, 1'b0, 1'b1, 1'b0, 12'd0, 1'b0),
            item_row(OP_TICK, 1'b0),
            chk_row(OP_TICK,  1'b1, 1'b0, 1'b0, 1'b1, 12'd0, 1'b0),
            // tiny clock: quotient far above the clamp
            cfg_row(REG_CLOCK_HZ, 28'd19),
            item_row(OP_START, 1'b0),
            item_row(OP_TICK, 1'b1),
            item_row(OP_TICK, 1'b1),
            item_row(OP_TICK, 1'b1),
            item_row(OP_TICK, 1'b0),
            chk_row(OP_TICK,  1'b1, 1'b0, 1'b0, 1'b1, 12'd4000, 1'b0)
        };

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[k]) begin
            if (dir_rows[k].kind == ROW_CFG) begin
                settle();
                write_reg(dir_rows[k].idx, dir_rows[k].data);
            end else begin
                offer_item(dir_rows[k].op, dir_rows[k].echo, want);
                due_readings.push_back(dir_rows[k].kind == ROW_CHK ? dir_rows[k].exp : want);
            end
        end

        // sender idles lightly, receiver heavily; long output hold-off in phase two
        run_phase(28'd190000, 12'd1, 22'h3FFFFF, 75, 0, 6, 78, 1'b0);
        run_phase(28'd1000000, 12'd3, 22'd200, 75, 0, 6, 78, 1'b1);
        run_phase(CLK_W'($urandom_range(19, 40000)), TRIG_W'($urandom_range(0, 6)),
                  TMO_W'($urandom_range(0, 400)), 75, 0, 6, 78, 1'b0);
        // roles swapped
        run_phase(28'd200000000, 12'd2, 22'd50, 75, 0, 78, 6, 1'b0);
        run_phase(28'hFFFFFFF, 12'd0, 22'd1, 75, 0, 78, 6, 1'b0);
        run_phase(CLK_W'($urandom_range(19, 40000)), TRIG_W'($urandom_range(0, 6)),
                  TMO_W'($urandom_range(0, 400)), 75, 0, 78, 6, 1'b0);
        // no idling; a long pulse must run to one full measurement
        run_phase(28'd80000000, 12'd150, 22'h3FFFFF, 20, 1, 0, 0, 1'b0);
        run_phase(CLK_W'($urandom_range(19, 40000)), TRIG_W'($urandom_range(0, 6)),
                  TMO_W'($urandom_range(0, 400)), 75, 0, 0, 0, 1'b0);
        run_phase(CLK_W'($urandom_range(19, 40000)), TRIG_W'($urandom_range(0, 6)),
                  TMO_W'($urandom_range(0, 400)), 75, 0, 0, 0, 1'b0);

        settle();
        // watch for extra results once every owed reading is back
        repeat (60) @(posedge i_clk);
        if (field_errors == 0 && due_readings.size() == 0)
            $display("ultrasonic_echo_ranger: match");
        else
            $display("ultrasonic_echo_ranger: mismatch");
        $finish;
    end

    initial begin : watchdog
        #10ms;
        $display("ultrasonic_echo_ranger: mismatch");
        $finish;
    end

endmodule
